/* src/rcfs_pkg.sv */
// ----------------------------------------------------------------------------
// rcfs_pkg
// constants, payload types and helpers for the failsafe differential mixer
// ----------------------------------------------------------------------------
package rcfs_pkg;

    // register indexes
    localparam logic CFG_FAILSAFE = 1'b0;
    localparam logic CFG_REPLY    = 1'b1;

    localparam logic [15:0] FAILSAFE_RESET    = 16'd500;
    localparam logic [7:0]  REPLY_RESET       = 8'd50;
    localparam logic [15:0] ROLL_LEVEL_RESET  = 16'd128;

    localparam logic [7:0] AUX_LEVEL_MASK = 8'hB1;
    localparam int         ARM_BIT        = 7;

    // map arithmetic constants
    localparam int ROLL_OFFSET = 296;
    localparam int ROLL_GAIN   = 255;
    localparam int ROLL_DIV    = 592;
    localparam int THR_OFFSET  = 60;
    localparam int THR_GAIN    = 500 / 20;
    localparam int THR_DIV     = 660 / 20;
    localparam int DRIVE_GAIN  = 255;
    localparam int DRIVE_DIV   = 494;
    localparam int BATT_GAIN   = 100;
    localparam int BATT_DIV    = 2282;
    localparam int BATT_BIAS   = 2;
    localparam int ROLL_CENTER = 128;

    // reciprocal divide: quotient is (n * recip) >> shift, off by at most one
    localparam int RECIP_SHIFT = 24;
    localparam int ROLL_RECIP  = (1 << RECIP_SHIFT) / ROLL_DIV;
    localparam int THR_RECIP   = (1 << RECIP_SHIFT) / THR_DIV;
    localparam int DRIVE_RECIP = (1 << RECIP_SHIFT) / DRIVE_DIV;
    localparam int BATT_RECIP  = (1 << RECIP_SHIFT) / BATT_DIV;

    localparam int MAG_W   = 16;
    localparam int GAIN_W  = 8;
    localparam int DIV_W   = 12;
    localparam int RECIP_W = 20;
    localparam int MUL_A_W = RECIP_SHIFT;
    localparam int MUL_B_W = RECIP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int QUO_W   = MUL_P_W - RECIP_SHIFT;

    typedef struct packed {
        logic        packet_present;
        logic        packet_long;
        logic [7:0]  aux_byte;
        logic [15:0] roll_word;
        logic [15:0] throttle_word;
        logic        link_up;
        logic [15:0] supply_mv;
    } in_item_t;

    function automatic logic [7:0] sat8(input logic signed [17:0] x);
        logic [7:0] r;
        if (x < 18'sd0) begin
            r = 8'd0;
        end else if (x > 18'sd255) begin
            r = 8'd255;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

/* src/rc_failsafe_diff_thrust_mixer.sv */
// ----------------------------------------------------------------------------
// rc_failsafe_diff_thrust_mixer
// failsafe differential-thrust mixer with telemetry battery code
// ----------------------------------------------------------------------------
// One control tick per input transaction, one result per tick. The block takes
// a tick in an idle state that accepts it, a run state in which a single shared 24x20
// multiplier runs four constant divisions (roll map, throttle map, drive scale,
// battery code) in four passes each (gain, reciprocal, back product, correction),
// and a finish state that waits for a free result register, then commits state
// and loads it. The next tick is taken while a result waits on m_tready.
// s_tuser: packet_present, packet_long. s_tdata: aux_byte, roll_word,
// throttle_word, link_up, supply_mv. m_tuser: reply_valid. m_tdata: left_drive,
// right_drive, battery_code, link_lost.
module rc_failsafe_diff_thrust_mixer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // aux_byte, roll_word, throttle_word, link_up, supply_mv
    input  logic [1:0]  s_tuser,   // packet_present, packet_long
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_drive, right_drive, battery_code, link_lost
    output logic [0:0]  m_tuser,   // reply_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [1:0] OP_ROLL  = 2'd0;
    localparam logic [1:0] OP_THR   = 2'd1;
    localparam logic [1:0] OP_DRIVE = 2'd2;
    localparam logic [1:0] OP_BATT  = 2'd3;

    localparam logic [1:0] PH_GAIN  = 2'd0;
    localparam logic [1:0] PH_RECIP = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;
    localparam logic [1:0] PH_FIX   = 2'd3;

    localparam int MA = rcfs_pkg::MUL_A_W;
    localparam int MB = rcfs_pkg::MUL_B_W;
    localparam int MP = rcfs_pkg::MUL_P_W;
    localparam int QW = rcfs_pkg::QUO_W;
    localparam int SH = rcfs_pkg::RECIP_SHIFT;

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg;
    logic [1:0] phase_reg;

    rcfs_pkg::in_item_t in_reg;

    logic [15:0] failsafe_ticks_reg;
    logic [7:0]  reply_every_reg;

    logic [7:0]  aux_flags_reg;
    logic [15:0] roll_level_reg;
    logic [15:0] throttle_level_reg;
    logic [7:0]  reply_counter_reg;
    logic [15:0] window_ticks_reg;
    logic        packet_seen_reg;
    logic [7:0]  held_left_reg;
    logic [7:0]  held_right_reg;

    logic [MA-1:0] n_reg;
    logic [QW-1:0] q_reg;
    logic [MA-1:0] p_reg;
    logic          neg_reg;

    logic [15:0] roll_q_reg;
    logic [15:0] thr_q_reg;
    logic [15:0] drive_q_reg;
    logic [15:0] batt_q_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // ---------------- handshakes ----------------
    logic s_fire, out_free, fin_fire;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // ---------------- packet decode ----------------
    logic upd_cmd, upd_lvl;
    logic [15:0] thr_sel;

    assign upd_cmd = in_reg.packet_present && in_reg.packet_long;
    assign upd_lvl = upd_cmd && (((in_reg.aux_byte & rcfs_pkg::AUX_LEVEL_MASK) != 8'd0)
                                 || (in_reg.aux_byte == 8'd0));
    assign thr_sel = upd_lvl ? thr_q_reg : throttle_level_reg;

    // ---------------- operand select ----------------
    logic [15:0] roll_r16, thr_t16;
    logic [16:0] roll_x17;
    logic [rcfs_pkg::MAG_W-1:0]   op_mag;
    logic                         op_neg;
    logic [rcfs_pkg::GAIN_W-1:0]  op_gain;
    logic [rcfs_pkg::DIV_W-1:0]   op_div;
    logic [rcfs_pkg::RECIP_W-1:0] op_recip;

    assign roll_r16 = in_reg.roll_word - 16'(rcfs_pkg::ROLL_OFFSET);
    assign roll_x17 = {roll_r16[15], roll_r16} + 17'(rcfs_pkg::ROLL_OFFSET);
    assign thr_t16  = in_reg.throttle_word + 16'(rcfs_pkg::THR_OFFSET);

    always_comb begin
        case (op_reg)
            OP_ROLL: begin
                op_neg   = roll_x17[16];
                op_mag   = roll_x17[16] ? 16'(-roll_x17) : roll_x17[15:0];
                op_gain  = 8'(rcfs_pkg::ROLL_GAIN);
                op_div   = 12'(rcfs_pkg::ROLL_DIV);
                op_recip = 20'(rcfs_pkg::ROLL_RECIP);
            end
            OP_THR: begin
                op_neg   = thr_t16[15];
                op_mag   = thr_t16[15] ? 16'(-thr_t16) : thr_t16;
                op_gain  = 8'(rcfs_pkg::THR_GAIN);
                op_div   = 12'(rcfs_pkg::THR_DIV);
                op_recip = 20'(rcfs_pkg::THR_RECIP);
            end
            OP_DRIVE: begin
                op_neg   = 1'b0;
                op_mag   = thr_sel;
                op_gain  = 8'(rcfs_pkg::DRIVE_GAIN);
                op_div   = 12'(rcfs_pkg::DRIVE_DIV);
                op_recip = 20'(rcfs_pkg::DRIVE_RECIP);
            end
            default: begin
                op_neg   = 1'b0;
                op_mag   = in_reg.supply_mv;
                op_gain  = 8'(rcfs_pkg::BATT_GAIN);
                op_div   = 12'(rcfs_pkg::BATT_DIV);
                op_recip = 20'(rcfs_pkg::BATT_RECIP);
            end
        endcase
    end

    // ---------------- shared multiplier ----------------
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [MP-1:0] mul_p;

    always_comb begin
        case (phase_reg)
            PH_GAIN: begin
                mul_a = MA'(op_mag);
                mul_b = MB'(op_gain);
            end
            PH_RECIP: begin
                mul_a = n_reg;
                mul_b = op_recip;
            end
            PH_BACK: begin
                mul_a = MA'(q_reg);
                mul_b = MB'(op_div);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MP'(mul_a) * MP'(mul_b);

    // correction step
    logic [MA-1:0] rem;
    logic [QW-1:0] q_fix;
    logic [15:0]   q_signed;

    assign rem      = n_reg - p_reg;
    assign q_fix    = q_reg + QW'(rem >= MA'(op_div));
    assign q_signed = neg_reg ? 16'(-q_fix[15:0]) : q_fix[15:0];

    // ---------------- tick commit ----------------
    logic [7:0]  aux1, aux2, aux3;
    logic [15:0] roll1;
    logic [8:0]  cnt9;
    logic        reply;
    logic [7:0]  counter_next;
    logic [7:0]  batt_code;
    logic        armed, m_zero, m_neg;
    logic signed [17:0] s18, roll18, l18, r18;
    logic [7:0]  left_next, right_next;
    logic [16:0] win_inc;
    logic        win_end, seen1, seen_next;
    logic [15:0] window_next;

    always_comb begin
        aux1  = upd_cmd ? in_reg.aux_byte : aux_flags_reg;
        roll1 = upd_lvl ? roll_q_reg : roll_level_reg;
        cnt9  = {1'b0, reply_counter_reg} + 9'(upd_cmd);
        reply = in_reg.packet_present && (cnt9 >= {1'b0, reply_every_reg});
        counter_next = reply ? 8'd0 : cnt9[7:0];
        batt_code = reply ? rcfs_pkg::sat8($signed({2'b00, batt_q_reg})
                                           - 18'(rcfs_pkg::BATT_BIAS))
                          : 8'd0;

        armed  = aux1[rcfs_pkg::ARM_BIT] && in_reg.link_up;
        m_zero = !armed || (thr_sel == 16'd0);
        m_neg  = armed && thr_sel[15];
        aux2   = in_reg.link_up ? aux1 : 8'd0;

        s18    = $signed({2'b00, drive_q_reg});
        roll18 = $signed({{2{roll1[15]}}, roll1});
        l18    = s18;
        r18    = s18;
        if (roll18 > 18'(rcfs_pkg::ROLL_CENTER)) begin
            r18 = s18 - (roll18 - 18'(rcfs_pkg::ROLL_CENTER));
        end else if (roll18 < 18'(rcfs_pkg::ROLL_CENTER)) begin
            l18 = s18 - (18'(rcfs_pkg::ROLL_CENTER) - roll18);
        end
        if (m_zero) begin
            left_next  = 8'd0;
            right_next = 8'd0;
        end else if (m_neg) begin
            left_next  = held_left_reg;
            right_next = held_right_reg;
        end else begin
            left_next  = rcfs_pkg::sat8(l18);
            right_next = rcfs_pkg::sat8(r18);
        end

        seen1   = upd_cmd || packet_seen_reg;
        win_inc = {1'b0, window_ticks_reg} + 17'd1;
        win_end = win_inc >= {1'b0, failsafe_ticks_reg};
        aux3    = aux2;
        seen_next   = seen1;
        window_next = win_inc[15:0];
        if (win_end) begin
            window_next = 16'd0;
            if (!seen1) begin
                aux3 = 8'd0;
            end else begin
                seen_next = 1'b0;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (phase_reg == PH_FIX && op_reg == OP_BATT) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            op_reg             <= OP_ROLL;
            phase_reg          <= PH_GAIN;
            failsafe_ticks_reg <= rcfs_pkg::FAILSAFE_RESET;
            reply_every_reg    <= rcfs_pkg::REPLY_RESET;
            aux_flags_reg      <= 8'd0;
            roll_level_reg     <= rcfs_pkg::ROLL_LEVEL_RESET;
            throttle_level_reg <= 16'd0;
            reply_counter_reg  <= 8'd0;
            window_ticks_reg   <= 16'd0;
            packet_seen_reg    <= 1'b0;
            held_left_reg      <= 8'd0;
            held_right_reg     <= 8'd0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rcfs_pkg::CFG_FAILSAFE: failsafe_ticks_reg <= cfg_data;
                    default:                reply_every_reg    <= cfg_data[7:0];
                endcase
            end

            if (s_fire) begin
                op_reg    <= OP_ROLL;
                phase_reg <= PH_GAIN;
            end else if (state_reg == ST_RUN) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_FIX) begin
                    op_reg <= op_reg + 2'd1;
                end
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (fin_fire) begin
                aux_flags_reg      <= aux3;
                roll_level_reg     <= roll1;
                throttle_level_reg <= thr_sel;
                reply_counter_reg  <= counter_next;
                window_ticks_reg   <= window_next;
                packet_seen_reg    <= seen_next;
                held_left_reg      <= left_next;
                held_right_reg     <= right_next;
                m_tvalid_reg       <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= {s_tuser[0], s_tuser[1], s_tdata[7:0], s_tdata[23:8],
                       s_tdata[39:24], s_tdata[40], s_tdata[56:41]};
        end
        if (state_reg == ST_RUN) begin
            case (phase_reg)
                PH_GAIN: begin
                    n_reg   <= mul_p[MA-1:0];
                    neg_reg <= op_neg;
                end
                PH_RECIP: begin
                    q_reg <= mul_p[MP-1:SH];
                end
                PH_BACK: begin
                    p_reg <= mul_p[MA-1:0];
                end
                default: begin
                    case (op_reg)
                        OP_ROLL:  roll_q_reg  <= q_signed;
                        OP_THR:   thr_q_reg   <= q_signed;
                        OP_DRIVE: drive_q_reg <= q_signed;
                        default:  batt_q_reg  <= q_signed;
                    endcase
                end
            endcase
        end
        if (fin_fire) begin
            m_tdata_reg <= {7'd0, !in_reg.link_up, batt_code, right_next, left_next};
            m_tuser_reg <= reply;
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the failsafe differential-thrust mixer
// ----------------------------------------------------------------------------
// Control ticks go in on the s_ stream and each one is mirrored by an
// in-bench mixer model that keeps its own flags, levels, counters and held
// drives. Every m_ transaction is matched field by field against the oldest
// predicted tick. Directed ticks cover the map extremes, arming, the aux mask,
// negative throttle hold, link loss, the silence window and registers lowered
// under a running counter. Random phases then run under several register
// settings, all but the last with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int ROLL_BIAS     = 296;
    localparam int ROLL_MUL      = 255;
    localparam int ROLL_DEN      = 592;
    localparam int THR_BIAS      = 60;
    localparam int THR_MUL       = 500;
    localparam int THR_DEN       = 660;
    localparam int SPEED_MUL     = 255;
    localparam int SPEED_DEN     = 494;
    localparam int MV_MUL        = 100;
    localparam int MV_DEN        = 2282;
    localparam int MV_BIAS       = 2;
    localparam int TRIM_CENTER   = 128;
    localparam int PHASE_TICKS   = 250;

    typedef struct {
        logic [7:0] left;
        logic [7:0] right;
        logic       reply;
        logic [7:0] batt;
        logic       lost;
    } tick_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // mixer model state
    logic [7:0]  arm_flags;
    int          roll_lvl;
    int          thr_lvl;
    int          pkt_count;
    int          tick_count;
    logic        heard_pkt;
    logic [7:0]  hold_left;
    logic [7:0]  hold_right;
    int          win_len;
    int          reply_period;

    tick_result_t mixer_outputs_q[$];
    tick_result_t want;
    int           mismatches;
    logic         steady_flow;
    int           rdy_hold;

    rc_failsafe_diff_thrust_mixer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic int to_s16(input int x);
        logic signed [15:0] v;
        v = x[15:0];
        return int'(v);
    endfunction

    function automatic logic [7:0] clamp_byte(input int x);
        logic [7:0] r;
        if (x < 0) begin
            r = 8'd0;
        end else if (x > 255) begin
            r = 8'd255;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

    function automatic tick_result_t mix_tick(input rcfs_pkg::in_item_t it);
        int           roll_in;
        int           thr_in;
        int           r;
        int           t;
        int           m;
        int           s;
        int           l;
        int           rr;
        int           nxt;
        tick_result_t res;
        roll_in = to_s16(int'(it.roll_word));
        thr_in = to_s16(int'(it.throttle_word));
        res.reply = 1'b0;
        res.batt = 8'd0;
        if (it.packet_present) begin
            if (it.packet_long) begin
                arm_flags = it.aux_byte;
                if ((it.aux_byte & rcfs_pkg::AUX_LEVEL_MASK) != 8'd0
                    || it.aux_byte == 8'd0) begin
                    r = to_s16(roll_in - ROLL_BIAS);
                    t = to_s16(thr_in + THR_BIAS);
                    roll_lvl = to_s16((r + ROLL_BIAS) * ROLL_MUL / ROLL_DEN);
                    thr_lvl = to_s16(t * THR_MUL / THR_DEN);
                end
                pkt_count = (pkt_count + 1) & 'h1FF;
                heard_pkt = 1'b1;
            end
            if (pkt_count >= reply_period) begin
                pkt_count = 0;
                res.reply = 1'b1;
                res.batt = clamp_byte(int'(it.supply_mv) * MV_MUL / MV_DEN - MV_BIAS);
            end
        end
        pkt_count = pkt_count & 'hFF;

        m = arm_flags[rcfs_pkg::ARM_BIT] ? thr_lvl : 0;
        if (!it.link_up) begin
            arm_flags = 8'd0;
            m = 0;
        end
        if (m == 0) begin
            hold_left = 8'd0;
            hold_right = 8'd0;
        end else if (m > 0) begin
            s = to_s16(m * SPEED_MUL / SPEED_DEN);
            l = s;
            rr = s;
            if (roll_lvl > TRIM_CENTER) begin
                rr = s - (roll_lvl - TRIM_CENTER);
            end else if (roll_lvl < TRIM_CENTER) begin
                l = s - (TRIM_CENTER - roll_lvl);
            end
            hold_left = clamp_byte(l);
            hold_right = clamp_byte(rr);
        end

        nxt = tick_count + 1;
        if (nxt >= win_len) begin
            tick_count = 0;
            if (!heard_pkt) begin
                arm_flags = 8'd0;
            end else begin
                heard_pkt = 1'b0;
            end
        end else begin
            tick_count = nxt & 'hFFFF;
        end

        res.left = hold_left;
        res.right = hold_right;
        res.lost = ~it.link_up;
        return res;
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int gap_len();
        if (steady_flow || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return stall_len();
    endfunction

    task automatic compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            if (mismatches < 10) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name,
                         exp_v, got_v);
            end
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mixer_outputs_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t unexpected transaction on m_ stream", $realtime);
                end
                mismatches++;
            end else begin
                want = mixer_outputs_q.pop_front();
                compare_field("left_drive", int'(want.left), int'(m_tdata[7:0]));
                compare_field("right_drive", int'(want.right), int'(m_tdata[15:8]));
                compare_field("battery_code", int'(want.batt), int'(m_tdata[23:16]));
                compare_field("link_lost", int'(want.lost), int'(m_tdata[24]));
                compare_field("reply_valid", int'(want.reply), int'(m_tuser[0]));
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready <= 1'b0;
            rdy_hold <= stall_len();
        end else begin
            m_tready <= 1'b1;
            rdy_hold <= $urandom_range(0, 8);
        end
    end

    task automatic send_tick(input logic present, input logic long_pkt, input logic [7:0] aux,
                             input logic [15:0] roll, input logic [15:0] thr,
                             input logic link, input logic [15:0] mv);
        rcfs_pkg::in_item_t it;
        int                 gap;
        it.packet_present = present;
        it.packet_long = long_pkt;
        it.aux_byte = aux;
        it.roll_word = roll;
        it.throttle_word = thr;
        it.link_up = link;
        it.supply_mv = mv;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, mv, link, thr, roll, aux};
        s_tuser <= {long_pkt, present};
        do @(posedge aclk); while (!s_tready);
        mixer_outputs_q.push_back(mix_tick(it));
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mixer_outputs_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == rcfs_pkg::CFG_FAILSAFE) begin
            win_len = int'(val);
        end else begin
            reply_period = int'(val[7:0]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int window, input int period);
        settle();
        write_reg(rcfs_pkg::CFG_FAILSAFE, 16'(window));
        write_reg(rcfs_pkg::CFG_REPLY, 16'(period));
    endtask

    task automatic random_tick();
        logic       present;
        logic       long_pkt;
        logic       link;
        logic [7:0] aux;
        logic [15:0] roll;
        logic [15:0] thr;
        logic [15:0] mv;
        if ($urandom_range(0, 99) < 8) begin
            present = 1'($urandom);
            long_pkt = 1'($urandom);
            aux = 8'($urandom);
            roll = 16'($urandom);
            thr = 16'($urandom);
            link = 1'($urandom);
            mv = 16'($urandom);
        end else begin
            present = $urandom_range(0, 99) < 75;
            long_pkt = $urandom_range(0, 9) != 0;
            aux = ($urandom_range(0, 3) != 0) ? (8'h80 | 8'($urandom)) : 8'($urandom);
            roll = 16'($urandom_range(0, 620));
            thr = 16'($urandom_range(0, 800) - 100);
            link = $urandom_range(0, 29) != 0;
            mv = $urandom_range(0, 1) ? 16'($urandom_range(2500, 9000)) : 16'($urandom);
        end
        send_tick(present, long_pkt, aux, roll, thr, link, mv);
    endtask

    task automatic test_startup();
        send_tick(1'b0, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000);
        send_tick(1'b0, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    endtask

    task automatic test_level_mapping();
        set_config(65535, 1);
        send_tick(1'b1, 1'b1, 8'h80, 16'd296, 16'd300, 1'b1, 16'd0);
        send_tick(1'b1, 1'b1, 8'h80, 16'd592, 16'd600, 1'b1, 16'hFFFF);
        send_tick(1'b1, 1'b1, 8'h80, 16'd0, 16'd300, 1'b1, 16'd5000);
        send_tick(1'b1, 1'b1, 8'h80, 16'd0, 16'hFFFF, 1'b1, 16'd2282);
        send_tick(1'b1, 1'b1, 8'h80, 16'h7FFF, 16'h7FFF, 1'b1, 16'd9999);
        send_tick(1'b1, 1'b1, 8'h80, 16'h8000, 16'h8000, 1'b1, 16'd3000);
        send_tick(1'b1, 1'b1, 8'hFF, 16'd100, 16'd500, 1'b1, 16'd1234);
        send_tick(1'b1, 1'b1, 8'h00, 16'd300, 16'd400, 1'b1, 16'd4000);
        send_tick(1'b1, 1'b1, 8'h40, 16'd0, 16'd0, 1'b1, 16'd4000);
        send_tick(1'b1, 1'b1, 8'hC0, 16'd450, 16'd450, 1'b1, 16'd4500);
        send_tick(1'b1, 1'b0, 8'hFF, 16'd0, 16'd0, 1'b1, 16'd7000);
        send_tick(1'b0, 1'b1, 8'hFF, 16'd0, 16'd0, 1'b1, 16'd7000);
    endtask

    task automatic test_link_loss();
        send_tick(1'b1, 1'b1, 8'h80, 16'd400, 16'd500, 1'b1, 16'd3700);
        send_tick(1'b0, 1'b0, 8'h80, 16'd400, 16'd500, 1'b0, 16'd3700);
        send_tick(1'b0, 1'b0, 8'h80, 16'd400, 16'd500, 1'b1, 16'd3700);
    endtask

    task automatic test_negative_hold();
        send_tick(1'b1, 1'b1, 8'h80, 16'd250, 16'd500, 1'b1, 16'd3900);
        send_tick(1'b1, 1'b1, 8'h80, 16'd250, 16'hFC00, 1'b1, 16'd3900);
    endtask

    task automatic test_silence_window();
        set_config(2, 1);
        send_tick(1'b1, 1'b1, 8'h80, 16'd296, 16'd400, 1'b1, 16'd4100);
        repeat (3) send_tick(1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 1'b1, 16'd4100);
    endtask

    task automatic test_lowered_limits();
        set_config(65535, 200);
        repeat (4) send_tick(1'b1, 1'b1, 8'h80, 16'd300, 16'd350, 1'b1, 16'd4200);
        settle();
        write_reg(rcfs_pkg::CFG_REPLY, 16'd2);
        send_tick(1'b1, 1'b0, 8'h80, 16'd300, 16'd350, 1'b1, 16'd4200);
        settle();
        write_reg(rcfs_pkg::CFG_FAILSAFE, 16'd3);
        send_tick(1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 1'b1, 16'd4200);
        send_tick(1'b0, 1'b0, 8'h00, 16'd0, 16'd0, 1'b1, 16'd4200);
    endtask

    task automatic test_random_phase(input int window, input int period, input logic steady);
        set_config(window, period);
        steady_flow = steady;
        repeat (PHASE_TICKS) random_tick();
        steady_flow = 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rcfs_pkg::CFG_FAILSAFE;
        cfg_data = '0;
        rdy_hold = 0;
        steady_flow = 1'b0;
        mismatches = 0;
        arm_flags = 8'd0;
        roll_lvl = TRIM_CENTER;
        thr_lvl = 0;
        pkt_count = 0;
        tick_count = 0;
        heard_pkt = 1'b0;
        hold_left = 8'd0;
        hold_right = 8'd0;
        win_len = int'(rcfs_pkg::FAILSAFE_RESET);
        reply_period = int'(rcfs_pkg::REPLY_RESET);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_startup();
        test_level_mapping();
        test_link_loss();
        test_negative_hold();
        test_silence_window();
        test_lowered_limits();
        test_random_phase(int'(rcfs_pkg::FAILSAFE_RESET), int'(rcfs_pkg::REPLY_RESET), 1'b0);
        test_random_phase(1, 1, 1'b0);
        test_random_phase(65535, 255, 1'b0);
        test_random_phase($urandom_range(2, 20), $urandom_range(2, 10), 1'b0);
        test_random_phase($urandom_range(1, 65535), $urandom_range(1, 255), 1'b1);

        settle();
        if (mismatches == 0 && mixer_outputs_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* rc_failsafe_diff_thrust_mixer.f */
src/rcfs_pkg.sv
src/rc_failsafe_diff_thrust_mixer.sv
test/tb.sv
